[hdl/lpe_pkg.sv]
// Shared constants, types and codes of the line position estimator.
package lpe_pkg;

  localparam int NUM_SENSORS = 9;
  localparam int SAMPLE_W    = 12;
  localparam int CENTRE      = (NUM_SENSORS - 1) / 2;
  localparam int IDX_W       = $clog2(NUM_SENSORS);
  localparam int OP_W        = 2;
  localparam int POS_OUT_W   = 12;

  localparam int CLAMP_W = SAMPLE_W + 7;
  localparam int PROD_W  = 2 * SAMPLE_W;
  localparam int LCNT_W  = $clog2(PROD_W + 1);
  localparam int SUM_W   = SAMPLE_W + $clog2(NUM_SENSORS);
  localparam int POS_W   = SUM_W + $clog2(CENTRE + 1) + 1;
  localparam int QNUM_W  = POS_W - 1 + 8;
  localparam int MCNT_W  = $clog2(QNUM_W + 1);

  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_CALIB   = 2'd1;
  localparam logic [OP_W-1:0] OP_MEASURE = 2'd2;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_IS_WHITE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NORM_MAX      = 1'd1;

  localparam logic [SAMPLE_W-1:0] ADC_MAX        = 12'd4095;
  localparam logic [SAMPLE_W-1:0] NORM_MAX_RESET = 12'd1000;

  localparam logic signed [POS_OUT_W-1:0] POS_MAX = 12'sd2047;
  localparam logic signed [POS_OUT_W-1:0] POS_MIN = -12'sd2048;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [NUM_SENSORS-1:0] sample_arr_t;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    sample_t         sample_0;
    sample_t         sample_1;
    sample_t         sample_2;
    sample_t         sample_3;
    sample_t         sample_4;
    sample_t         sample_5;
    sample_t         sample_6;
    sample_t         sample_7;
    sample_t         sample_8;
  } sweep_t;

  typedef struct packed {
    logic signed [POS_OUT_W-1:0] position;
    logic                        line_lost;
  } result_t;

  typedef struct packed {
    logic clear;
    logic calib;
    logic start;
  } lane_ctrl_t;

endpackage

[hdl/lpe_if.sv]
// Valid/ready channel interfaces for sweeps and results.
interface lpe_sweep_if;
  logic             valid;
  logic             ready;
  lpe_pkg::sweep_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lpe_result_if;
  logic             valid;
  logic             ready;
  lpe_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/lpe_lane.sv]
// One sensor lane: calibration store, clamp and iterative normalising divider.
module lpe_lane (
  input  logic                clk,
  input  logic                rst,
  input  lpe_pkg::lane_ctrl_t ctrl,
  input  lpe_pkg::sample_t    sample,
  input  lpe_pkg::sample_t    norm_max,
  input  logic                line_is_white,
  output lpe_pkg::sample_t    v,
  output logic                done
);

  localparam logic [1:0] L_IDLE  = 2'd0;
  localparam logic [1:0] L_CLAMP = 2'd1;
  localparam logic [1:0] L_MUL   = 2'd2;
  localparam logic [1:0] L_DIV   = 2'd3;

  logic [1:0]                    state;
  lpe_pkg::sample_t              mn, mx, s, diff, den, rem;
  logic                          zero;
  logic [lpe_pkg::PROD_W-1:0]    num;
  logic [lpe_pkg::LCNT_W-1:0]    cnt;
  logic [lpe_pkg::CLAMP_W-1:0]   s_x100, mn_x115, mx_x85;
  lpe_pkg::sample_t              s_cl, vq;
  logic [lpe_pkg::SAMPLE_W:0]    rem_sh;

  always_comb begin
    s_x100  = lpe_pkg::CLAMP_W'(s) * lpe_pkg::CLAMP_W'(100);
    mn_x115 = lpe_pkg::CLAMP_W'(mn) * lpe_pkg::CLAMP_W'(115);
    mx_x85  = lpe_pkg::CLAMP_W'(mx) * lpe_pkg::CLAMP_W'(85);
    if (s_x100 < mn_x115) begin
      s_cl = mn;
    end else if (s_x100 > mx_x85) begin
      s_cl = mx;
    end else begin
      s_cl = s;
    end
    rem_sh = {rem, num[lpe_pkg::PROD_W-1]};
    if (num > lpe_pkg::PROD_W'(norm_max)) begin
      vq = norm_max;
    end else begin
      vq = num[lpe_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
      mn    <= lpe_pkg::ADC_MAX;
      mx    <= '0;
    end else begin
      if (ctrl.clear) begin
        mn <= lpe_pkg::ADC_MAX;
        mx <= '0;
      end else if (ctrl.calib) begin
        if (sample < mn) begin
          mn <= sample;
        end
        if (sample > mx) begin
          mx <= sample;
        end
      end
      case (state)
        L_IDLE: begin
          if (ctrl.start) begin
            s     <= sample;
            done  <= 1'b0;
            state <= L_CLAMP;
          end
        end
        L_CLAMP: begin
          zero  <= (mx <= mn) || (s_cl < mn);
          diff  <= s_cl - mn;
          den   <= mx - mn;
          state <= L_MUL;
        end
        L_MUL: begin
          num   <= zero ? '0 : lpe_pkg::PROD_W'(norm_max) * lpe_pkg::PROD_W'(diff);
          rem   <= '0;
          cnt   <= zero ? '0 : lpe_pkg::LCNT_W'(lpe_pkg::PROD_W);
          state <= L_DIV;
        end
        L_DIV: begin
          if (cnt != '0) begin
            if (rem_sh >= {1'b0, den}) begin
              rem <= lpe_pkg::SAMPLE_W'(rem_sh - {1'b0, den});
              num <= {num[lpe_pkg::PROD_W-2:0], 1'b1};
            end else begin
              rem <= rem_sh[lpe_pkg::SAMPLE_W-1:0];
              num <= {num[lpe_pkg::PROD_W-2:0], 1'b0};
            end
            cnt <= cnt - 1'b1;
          end else begin
            v     <= line_is_white ? norm_max - vq : vq;
            done  <= 1'b1;
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

[hdl/lpe_merge.sv]
// Merging stage: weighted sums over the lanes and the signed centroid divider.
module lpe_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lpe_pkg::sample_arr_t v,
  output lpe_pkg::result_t     res,
  output logic                 done
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_ACC  = 2'd1;
  localparam logic [1:0] M_PREP = 2'd2;
  localparam logic [1:0] M_DIV  = 2'd3;

  logic [1:0]                        state;
  logic [lpe_pkg::IDX_W-1:0]         idx;
  logic [lpe_pkg::SUM_W-1:0]         sum, den, rem;
  logic signed [lpe_pkg::POS_W-1:0]  pos, term;
  logic signed [lpe_pkg::IDX_W:0]    w;
  logic [lpe_pkg::POS_W-2:0]         mag;
  logic [lpe_pkg::QNUM_W-1:0]        num;
  logic [lpe_pkg::MCNT_W-1:0]        cnt;
  logic                              neg;
  logic [lpe_pkg::SUM_W:0]           rem_sh;

  always_comb begin
    w    = $signed({1'b0, idx}) - $signed((lpe_pkg::IDX_W + 1)'(lpe_pkg::CENTRE));
    term = lpe_pkg::POS_W'(w) * $signed(lpe_pkg::POS_W'(v[idx]));
    mag  = pos[lpe_pkg::POS_W-1] ? (lpe_pkg::POS_W - 1)'(-pos) : (lpe_pkg::POS_W - 1)'(pos);
    rem_sh = {rem, num[lpe_pkg::QNUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        M_IDLE: begin
          if (start) begin
            idx   <= '0;
            sum   <= '0;
            pos   <= '0;
            done  <= 1'b0;
            state <= M_ACC;
          end
        end
        M_ACC: begin
          sum <= sum + lpe_pkg::SUM_W'(v[idx]);
          pos <= pos + term;
          idx <= idx + 1'b1;
          if (idx == lpe_pkg::IDX_W'(lpe_pkg::NUM_SENSORS - 1)) begin
            state <= M_PREP;
          end
        end
        M_PREP: begin
          if (sum == '0) begin
            res.position  <= '0;
            res.line_lost <= 1'b1;
            done          <= 1'b1;
            state         <= M_IDLE;
          end else begin
            neg   <= pos[lpe_pkg::POS_W-1];
            num   <= {mag, 8'd0};
            den   <= sum;
            rem   <= '0;
            cnt   <= lpe_pkg::MCNT_W'(lpe_pkg::QNUM_W);
            state <= M_DIV;
          end
        end
        M_DIV: begin
          if (cnt != '0) begin
            if (rem_sh >= {1'b0, den}) begin
              rem <= lpe_pkg::SUM_W'(rem_sh - {1'b0, den});
              num <= {num[lpe_pkg::QNUM_W-2:0], 1'b1};
            end else begin
              rem <= rem_sh[lpe_pkg::SUM_W-1:0];
              num <= {num[lpe_pkg::QNUM_W-2:0], 1'b0};
            end
            cnt <= cnt - 1'b1;
          end else begin
            if (neg) begin
              if (num > lpe_pkg::QNUM_W'(2048)) begin
                res.position <= lpe_pkg::POS_MIN;
              end else begin
                res.position <= -$signed(lpe_pkg::POS_OUT_W'(num));
              end
            end else if (num > lpe_pkg::QNUM_W'(2047)) begin
              res.position <= lpe_pkg::POS_MAX;
            end else begin
              res.position <= $signed(lpe_pkg::POS_OUT_W'(num));
            end
            res.line_lost <= 1'b0;
            done          <= 1'b1;
            state         <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

[hdl/line_position_estimator_top.sv]
// Top level of the line position estimator: lanes, merging stage and handshakes.
//
// A clear or calibration transaction is absorbed on acceptance and produces no
// result. For a measurement, each sensor lane runs a 24-step normalising
// divider, and the merging stage then accumulates the nine lanes and runs a
// 27-step divider for the Q8 centroid; that divider is skipped when the line is
// lost. One sweep is in flight at a time; the next sweep is accepted while a
// finished result waits in the output register.
module line_position_estimator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lpe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lpe_pkg::CFG_DATA_W-1:0]    cfg_data,
  lpe_sweep_if.sink                         sweep,
  lpe_result_if.source                      result
);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_LANES = 2'd1;
  localparam logic [1:0] T_MERGE = 2'd2;

  logic [1:0]                       state;
  logic                             line_is_white;
  lpe_pkg::sample_t                 norm_max;
  lpe_pkg::sample_arr_t             samples, lane_v;
  logic [lpe_pkg::NUM_SENSORS-1:0]  lane_done;
  lpe_pkg::lane_ctrl_t              lane_ctrl;
  logic                             accept, merge_start, merge_done, load;
  lpe_pkg::result_t                 merge_res;

  assign sweep.ready = (state == T_IDLE);
  assign accept      = sweep.valid && sweep.ready;
  assign merge_start = (state == T_LANES) && (&lane_done);
  assign load        = (state == T_MERGE) && merge_done && (!result.valid || result.ready);

  always_comb begin
    lane_ctrl.clear = accept && (sweep.payload.operation == lpe_pkg::OP_CLEAR);
    lane_ctrl.calib = accept && (sweep.payload.operation == lpe_pkg::OP_CALIB);
    lane_ctrl.start = accept && (sweep.payload.operation == lpe_pkg::OP_MEASURE);
    samples[0] = sweep.payload.sample_0;
    samples[1] = sweep.payload.sample_1;
    samples[2] = sweep.payload.sample_2;
    samples[3] = sweep.payload.sample_3;
    samples[4] = sweep.payload.sample_4;
    samples[5] = sweep.payload.sample_5;
    samples[6] = sweep.payload.sample_6;
    samples[7] = sweep.payload.sample_7;
    samples[8] = sweep.payload.sample_8;
  end

  for (genvar i = 0; i < lpe_pkg::NUM_SENSORS; i++) begin : g_lane
    lpe_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (lane_ctrl),
      .sample        (samples[i]),
      .norm_max      (norm_max),
      .line_is_white (line_is_white),
      .v             (lane_v[i]),
      .done          (lane_done[i])
    );
  end

  lpe_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (merge_start),
    .v     (lane_v),
    .res   (merge_res),
    .done  (merge_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_is_white <= 1'b0;
      norm_max      <= lpe_pkg::NORM_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lpe_pkg::CFG_LINE_IS_WHITE: line_is_white <= cfg_data[0];
        lpe_pkg::CFG_NORM_MAX:      norm_max <= cfg_data[lpe_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (lane_ctrl.start) begin
            state <= T_LANES;
          end
        end
        T_LANES: begin
          if (merge_start) begin
            state <= T_MERGE;
          end
        end
        T_MERGE: begin
          if (load) begin
            result.payload <= merge_res;
            state          <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_lost_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.line_lost |-> result.payload.position == '0)
    else $error("Lost line reported with a non-zero position.");

  a_measure_starts: assert property (@(posedge clk) disable iff (rst)
    lane_ctrl.start |=> state == T_LANES)
    else $error("Accepted measurement did not start the lanes.");

  a_lanes_held: assert property (@(posedge clk) disable iff (rst)
    state == T_MERGE |-> &lane_done)
    else $error("Lane result changed while the merging stage was working.");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    state == T_MERGE && merge_done && (!result.valid || result.ready)
    |=> result.valid && state == T_IDLE)
    else $error("Finished centroid was not presented.");

endmodule

[verif/lpe_tb_if.sv]
// Testbench-side copy of nothing: the interfaces come from the RTL; this file holds helper types.
`timescale 1ns / 100ps
package lpe_tb_pkg;
  typedef enum int {KIND_DARK, KIND_LINE, KIND_ANY} sweep_kind_e;
  localparam logic [1:0] OP_UNUSED = 2'd3;
endpackage

[verif/tb.sv]
// Testbench of the line position estimator: directed and random sweeps checked against a predictor.
`timescale 1ns / 100ps
module tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [lpe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [lpe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  lpe_sweep_if sweep ();
  lpe_result_if result ();

  line_position_estimator_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sweep(sweep), .result(result)
  );

  always #5 clk = ~clk;

  logic white_line;
  int unsigned full_scale;
  int unsigned cal_low [lpe_pkg::NUM_SENSORS];
  int unsigned cal_high [lpe_pkg::NUM_SENSORS];
  lpe_pkg::result_t expected_positions [$];
  int error_count = 0;
  int idle_cycles = 0;
  int sweeps_sent = 0;
  int positions_seen = 0;
  bit stall_enable = 1'b1;

  function automatic lpe_pkg::sample_t sample_at(lpe_pkg::sweep_t s, int i);
    lpe_pkg::sample_arr_t arr;
    arr = {s.sample_0, s.sample_1, s.sample_2, s.sample_3, s.sample_4,
           s.sample_5, s.sample_6, s.sample_7, s.sample_8};
    return arr[lpe_pkg::NUM_SENSORS-1-i];
  endfunction

  function automatic int unsigned scaled_reading(int unsigned s, int unsigned lo,
                                                 int unsigned hi);
    longint unsigned v;
    if (100 * s < 115 * lo) s = lo;
    else if (100 * s > 85 * hi) s = hi;
    if (hi <= lo || s < lo) return 0;
    v = (longint'(full_scale) * (s - lo)) / (hi - lo);
    if (v > full_scale) v = full_scale;
    return int'(v);
  endfunction

  task automatic predict_sweep(lpe_pkg::sweep_t s);
    longint total, moment, q;
    int unsigned v;
    lpe_pkg::result_t r;
    total = 0;
    moment = 0;
    case (s.operation)
      lpe_pkg::OP_CLEAR: begin
        foreach (cal_low[i]) begin
          cal_low[i] = lpe_pkg::ADC_MAX;
          cal_high[i] = 0;
        end
      end
      lpe_pkg::OP_CALIB: begin
        for (int i = 0; i < lpe_pkg::NUM_SENSORS; i++) begin
          if (sample_at(s, i) < cal_low[i]) cal_low[i] = sample_at(s, i);
          if (sample_at(s, i) > cal_high[i]) cal_high[i] = sample_at(s, i);
        end
      end
      lpe_pkg::OP_MEASURE: begin
        for (int i = 0; i < lpe_pkg::NUM_SENSORS; i++) begin
          v = scaled_reading(sample_at(s, i), cal_low[i], cal_high[i]);
          if (white_line) v = full_scale - v;
          total += v;
          moment += longint'(i - lpe_pkg::CENTRE) * v;
        end
        if (total == 0) begin
          r.position = '0;
          r.line_lost = 1'b1;
        end else begin
          q = (moment * 256) / total;
          if (q > 2047) q = 2047;
          if (q < -2048) q = -2048;
          r.position = q[lpe_pkg::POS_OUT_W-1:0];
          r.line_lost = 1'b0;
        end
        expected_positions.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what);
    error_count++;
    $display("Mismatch at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      positions_seen++;
      if (expected_positions.size() == 0) begin
        report_mismatch("position result with none outstanding");
      end else begin
        if (result.payload.position !== expected_positions[0].position)
          report_mismatch($sformatf("position %0d, expected %0d", result.payload.position,
                                    expected_positions[0].position));
        if (result.payload.line_lost !== expected_positions[0].line_lost)
          report_mismatch($sformatf("line_lost %0b, expected %0b",
                                    result.payload.line_lost, expected_positions[0].line_lost));
        void'(expected_positions.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || !stall_enable) result.ready <= 1'b1;
    else if ($urandom_range(0, 7) == 0) result.ready <= 1'b1;
    else result.ready <= ($urandom_range(0, 3) != 0) && ($time % 700 > 120);
  end

  always @(posedge clk) begin
    if ((sweep.valid && sweep.ready) || (result.valid && result.ready) || rst)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_positions.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_sweep(lpe_pkg::sweep_t s);
    sweep.valid <= 1'b1;
    sweep.payload <= s;
    @(negedge clk);
    while (!sweep.ready) @(negedge clk);
    @(posedge clk);
    predict_sweep(s);
    sweeps_sent++;
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      sweep.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
  endtask

  task automatic write_register(logic [lpe_pkg::CFG_INDEX_W-1:0] index, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value[lpe_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (index == lpe_pkg::CFG_LINE_IS_WHITE) white_line = value[0];
    else full_scale = value[lpe_pkg::CFG_DATA_W-1:0];
  endtask

  task automatic wait_until_idle();
    sweep.valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic lpe_pkg::sweep_t make_sweep(logic [lpe_pkg::OP_W-1:0] op,
                                                 lpe_tb_pkg::sweep_kind_e kind);
    lpe_pkg::sample_arr_t arr;
    int peak;
    lpe_pkg::sweep_t s;
    peak = $urandom_range(0, lpe_pkg::NUM_SENSORS - 1);
    for (int i = 0; i < lpe_pkg::NUM_SENSORS; i++) begin
      case (kind)
        lpe_tb_pkg::KIND_DARK: arr[i] = $urandom_range(0, 400);
        lpe_tb_pkg::KIND_LINE: begin
          if (i == peak) arr[i] = $urandom_range(3000, 4095);
          else if (i == peak + 1 || i == peak - 1) arr[i] = $urandom_range(900, 3200);
          else arr[i] = $urandom_range(50, 700);
        end
        default: arr[i] = $urandom_range(0, 4095);
      endcase
    end
    s = {op, arr[0], arr[1], arr[2], arr[3], arr[4], arr[5], arr[6], arr[7], arr[8]};
    return s;
  endfunction

  function automatic lpe_pkg::sweep_t flat_sweep(logic [lpe_pkg::OP_W-1:0] op,
                                                 lpe_pkg::sample_t value);
    return {op, {lpe_pkg::NUM_SENSORS{value}}};
  endfunction

  task automatic test_uncalibrated();
    send_sweep(flat_sweep(lpe_pkg::OP_MEASURE, 12'd2000));
    idle_gap();
    wait_until_idle();
    write_register(lpe_pkg::CFG_LINE_IS_WHITE, 1);
    send_sweep(flat_sweep(lpe_pkg::OP_MEASURE, 12'd0));
    wait_until_idle();
    write_register(lpe_pkg::CFG_LINE_IS_WHITE, 0);
  endtask

  task automatic test_directed();
    send_sweep(flat_sweep(lpe_pkg::OP_CLEAR, 12'd0));
    send_sweep(flat_sweep(lpe_pkg::OP_CALIB, 12'd0));
    send_sweep(flat_sweep(lpe_pkg::OP_CALIB, 12'hFFF));
    send_sweep(flat_sweep(lpe_pkg::OP_MEASURE, 12'hFFF));
    send_sweep(flat_sweep(lpe_pkg::OP_MEASURE, 12'd0));
    send_sweep(flat_sweep(lpe_pkg::OP_MEASURE, 12'hAAA));
    send_sweep(flat_sweep(lpe_pkg::OP_MEASURE, 12'h555));
    send_sweep({lpe_pkg::OP_MEASURE, 12'hFFF, {8{12'd0}}});
    send_sweep({lpe_pkg::OP_MEASURE, {8{12'd0}}, 12'hFFF});
    send_sweep(flat_sweep(lpe_tb_pkg::OP_UNUSED, 12'h123));
    send_sweep(make_sweep(lpe_pkg::OP_MEASURE, lpe_tb_pkg::KIND_LINE));
    send_sweep(flat_sweep(lpe_pkg::OP_CLEAR, 12'hFFF));
    send_sweep(make_sweep(lpe_pkg::OP_MEASURE, lpe_tb_pkg::KIND_ANY));
    wait_until_idle();
  endtask

  task automatic test_settings();
    int unsigned scales [4] = '{1, 4095, 1000, 37};
    foreach (scales[k]) begin
      write_register(lpe_pkg::CFG_NORM_MAX, scales[k]);
      write_register(lpe_pkg::CFG_LINE_IS_WHITE, k % 2);
      send_sweep(flat_sweep(lpe_pkg::OP_CLEAR, 12'd0));
      repeat (3) send_sweep(make_sweep(lpe_pkg::OP_CALIB, lpe_tb_pkg::KIND_DARK));
      repeat (3) send_sweep(make_sweep(lpe_pkg::OP_CALIB, lpe_tb_pkg::KIND_LINE));
      repeat (6) send_sweep(make_sweep(lpe_pkg::OP_MEASURE, lpe_tb_pkg::KIND_LINE));
      wait_until_idle();
    end
    write_register(lpe_pkg::CFG_NORM_MAX, 0);
    send_sweep(make_sweep(lpe_pkg::OP_MEASURE, lpe_tb_pkg::KIND_LINE));
    wait_until_idle();
  endtask

  task automatic test_random();
    int burst;
    int unsigned roll;
    for (int phase = 0; phase < 5; phase++) begin
      write_register(lpe_pkg::CFG_NORM_MAX, (phase == 0) ? 4095 : $urandom_range(1, 4095));
      write_register(lpe_pkg::CFG_LINE_IS_WHITE, $urandom_range(0, 1));
      stall_enable = (phase != 2);
      send_sweep(flat_sweep(lpe_pkg::OP_CLEAR, 12'd0));
      repeat ($urandom_range(2, 6))
        send_sweep(make_sweep(lpe_pkg::OP_CALIB, lpe_tb_pkg::KIND_DARK));
      repeat ($urandom_range(4, 10))
        send_sweep(make_sweep(lpe_pkg::OP_CALIB, lpe_tb_pkg::KIND_LINE));
      for (int n = 0; n < 85;) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && n < 85; b++, n++) begin
          roll = $urandom_range(0, 99);
          if (roll < 70)
            send_sweep(make_sweep(lpe_pkg::OP_MEASURE, lpe_tb_pkg::KIND_LINE));
          else if (roll < 85)
            send_sweep(make_sweep(lpe_pkg::OP_MEASURE, lpe_tb_pkg::KIND_ANY));
          else if (roll < 95)
            send_sweep(make_sweep(lpe_pkg::OP_CALIB, lpe_tb_pkg::KIND_ANY));
          else if (roll < 98)
            send_sweep(make_sweep(lpe_tb_pkg::OP_UNUSED, lpe_tb_pkg::KIND_ANY));
          else send_sweep(make_sweep(lpe_pkg::OP_CLEAR, lpe_tb_pkg::KIND_ANY));
        end
        if (phase != 2) pause($urandom_range(0, 12));
      end
      wait_until_idle();
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    sweep.valid = 1'b0;
    sweep.payload = '0;
    white_line = 1'b0;
    full_scale = lpe_pkg::NORM_MAX_RESET;
    foreach (cal_low[i]) begin
      cal_low[i] = lpe_pkg::ADC_MAX;
      cal_high[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_uncalibrated();
    test_directed();
    test_settings();
    test_random();
    $display("Covered %0d sweeps and %0d position results", sweeps_sent, positions_seen);
    $display("over four fixed and five random calibration and register settings.");
    if (error_count == 0 && expected_positions.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
